### src/key_and_mouse_autorepeat_defines.svh
// Assertion macros used by the checker file kmar_checker.sv.
`ifndef KEY_AND_MOUSE_AUTOREPEAT_DEFINES_SVH
`define KEY_AND_MOUSE_AUTOREPEAT_DEFINES_SVH

// Same-cycle implication, masked while reset is low.
`define KMAR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is low.
`define KMAR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define KMAR_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### src/kmar_pkg.sv
package kmar_pkg;

  localparam int KEY_CODES     = 512;
  localparam int STACK_DEPTH   = 32;
  localparam int MOUSE_BUTTONS = 8;

  localparam int KEY_AW = (KEY_CODES > 1) ? $clog2(KEY_CODES) : 1;
  localparam int SP_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

  localparam int KEY_W  = 9;
  localparam int CHAR_W = 16;
  localparam int BTN_W  = 4;
  localparam int TIME_W = 32;
  localparam int RATE_W = 16;
  localparam int HELD_W = 8;
  localparam int IN_W   = 72;
  localparam int OUT_W  = 64;
  localparam int CFG_AW = 8;

  localparam logic [KEY_W-1:0] MOD_RSHIFT = 9'd303;
  localparam logic [KEY_W-1:0] MOD_LALT   = 9'd308;

  typedef enum logic [2:0] {
    FN_KEY_DOWN   = 3'd0,
    FN_KEY_UP     = 3'd1,
    FN_MOUSE_DOWN = 3'd2,
    FN_MOUSE_UP   = 3'd3,
    FN_POLL       = 3'd4
  } func_t;

  typedef enum logic [CFG_AW-1:0] {
    CFG_KEY_DELAY   = 8'd0,
    CFG_KEY_RATE    = 8'd1,
    CFG_MOUSE_DELAY = 8'd2,
    CFG_MOUSE_RATE  = 8'd3
  } cfg_idx_t;

  // Key map entry and mouse repeat phase share the same coding.
  localparam logic [1:0] MAP_UP     = 2'd0;
  localparam logic [1:0] MAP_HELD   = 2'd1;
  localparam logic [1:0] MAP_REPEAT = 2'd2;

  localparam logic [1:0] DRAG_IDLE    = 2'd0;
  localparam logic [1:0] DRAG_PRESSED = 2'd1;
  localparam logic [1:0] DRAG_ACTIVE  = 2'd2;

  typedef struct packed {
    logic              en;
    logic [KEY_AW-1:0] addr;
    logic [1:0]        data;
  } map_wr_t;

  typedef struct packed {
    logic [CHAR_W-1:0] chr;
    logic [KEY_W-1:0]  key;
  } stk_entry_t;

  function automatic logic key_in_range(input logic [KEY_W-1:0] k);
    return 32'(k) < KEY_CODES;
  endfunction

  function automatic logic [KEY_AW-1:0] key_index(input logic [KEY_W-1:0] k);
    return KEY_AW'(k);
  endfunction

  function automatic logic is_modifier(input logic [KEY_W-1:0] k);
    return (k >= MOD_RSHIFT) && (k <= MOD_LALT);
  endfunction

endpackage

### src/kmar_keymap.sv
module kmar_keymap
  import kmar_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [KEY_W-1:0] rd_a_key,
  input  logic [KEY_W-1:0] rd_b_key,
  input  map_wr_t          wr,
  output logic [1:0]       rd_a_state,
  output logic [1:0]       rd_b_state,
  output logic             busy
);

  logic [1:0]        mem [KEY_CODES];
  logic              clr_r;
  logic [KEY_AW-1:0] clr_idx_r;
  logic [1:0]        a_q_r, b_q_r;
  logic              a_ok_r, b_ok_r;

  // Sweep zeros through every entry after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_idx_r <= '0;
    end else if (clr_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (32'(clr_idx_r) == KEY_CODES - 1) clr_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_r) begin
      mem[clr_idx_r] <= MAP_UP;
    end else if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      a_q_r  <= mem[key_index(rd_a_key)];
      b_q_r  <= mem[key_index(rd_b_key)];
      a_ok_r <= key_in_range(rd_a_key);
      b_ok_r <= key_in_range(rd_b_key);
    end
  end

  assign rd_a_state = a_ok_r ? a_q_r : MAP_UP;
  assign rd_b_state = b_ok_r ? b_q_r : MAP_UP;
  assign busy       = clr_r;

endmodule

### src/key_and_mouse_autorepeat.sv
// Typematic autorepeat engine for key and mouse events. Each accepted beat
// yields exactly one result beat. The accept edge issues reads of the key
// map RAM (repeat key and query key) and of the repeat stack RAM; the item
// then waits in the s1 registers until the output register can take it,
// when the result is computed and written back. in_tready stays low while
// an item waits there. A finished result waits in the output register
// without blocking the next accept. After reset the key map is cleared in a
// pass during which in_tready stays low; configuration writes are taken at any time.
module key_and_mouse_autorepeat
  import kmar_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // key_code[8:0], char_code[24:9], button[28:25], now_ms[60:29],
  // query_key[69:61], zero fill above
  input  logic [IN_W-1:0]  in_tdata,
  // func[2:0]
  input  logic [2:0]       in_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  // last_key[8:0], last_char[24:9], last_pressed[33:25], last_released[42:34],
  // mouse_button[46:43], buttons_held[54:47], drag_state[56:55],
  // event_flag[57], query_state[59:58], zero fill above
  output logic [OUT_W-1:0] out_tdata,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [RATE_W-1:0] cfg_data
);

  // configuration
  logic [RATE_W-1:0] key_delay_r, key_rate_r, mouse_delay_r, mouse_rate_r;

  // item in flight
  logic              s1_valid_r;
  logic [2:0]        s1_func_r;
  logic [KEY_W-1:0]  s1_key_r;
  logic [CHAR_W-1:0] s1_char_r;
  logic [BTN_W-1:0]  s1_button_r;
  logic [TIME_W-1:0] s1_now_r;
  logic [KEY_W-1:0]  s1_query_r;

  // engine state
  logic [KEY_W-1:0]  repeat_key_r, repeat_key_nxt;
  logic [CHAR_W-1:0] repeat_char_r, repeat_char_nxt;
  logic [CNT_W-1:0]  stack_count_r, stack_count_nxt;
  logic [TIME_W-1:0] key_time_r, key_time_nxt;
  logic [KEY_W-1:0]  frame_key_r, frame_key_nxt;
  logic [CHAR_W-1:0] frame_char_r, frame_char_nxt;
  logic [KEY_W-1:0]  pressed_key_r, pressed_key_nxt;
  logic [KEY_W-1:0]  released_key_r, released_key_nxt;
  logic [HELD_W-1:0] held_buttons_r, held_buttons_nxt;
  logic [BTN_W-1:0]  repeat_button_r, repeat_button_nxt;
  logic [1:0]        mouse_phase_r, mouse_phase_nxt;
  logic [1:0]        drag_r, drag_nxt;
  logic [TIME_W-1:0] mouse_time_r, mouse_time_nxt;
  logic [BTN_W-1:0]  frame_button_r, frame_button_nxt;

  logic              out_valid_r;
  logic [OUT_W-1:0]  out_data_r, out_data_nxt;

  // memories
  stk_entry_t        stk_mem [STACK_DEPTH];
  stk_entry_t        stk_rd_r;
  logic [SP_W-1:0]   stk_rd_addr;
  logic              push;

  map_wr_t           map_wr;
  logic [1:0]        map_a_state, map_b_state;
  logic              map_busy;

  logic              in_accept, fire, poll, flag;
  logic [1:0]        query_state;
  logic              button_ok;
  logic [TIME_W-1:0] key_diff, mouse_diff;
  logic              key_due, mouse_due;

  assign cfg_ready  = 1'b1;
  assign in_tready  = !map_busy && !s1_valid_r;
  assign in_accept  = in_tvalid && in_tready;
  assign fire       = s1_valid_r && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_delay_r   <= 16'd250;
      key_rate_r    <= 16'd33;
      mouse_delay_r <= 16'd200;
      mouse_rate_r  <= 16'd10;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        CFG_KEY_DELAY:   key_delay_r   <= cfg_data;
        CFG_KEY_RATE:    key_rate_r    <= cfg_data;
        CFG_MOUSE_DELAY: mouse_delay_r <= cfg_data;
        CFG_MOUSE_RATE:  mouse_rate_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  kmar_keymap u_keymap (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_en      (in_accept),
    .rd_a_key   (repeat_key_r),
    .rd_b_key   (in_tdata[69:61]),
    .wr         (map_wr),
    .rd_a_state (map_a_state),
    .rd_b_state (map_b_state),
    .busy       (map_busy)
  );

  // Top of stack, read ahead at accept in case the item pops.
  assign stk_rd_addr = SP_W'(stack_count_r - 1'b1);

  always_ff @(posedge clk) begin
    if (in_accept) stk_rd_r <= stk_mem[stk_rd_addr];
    if (fire && push) stk_mem[SP_W'(stack_count_r)] <= '{chr: repeat_char_r, key: repeat_key_r};
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_func_r   <= in_tuser;
      s1_key_r    <= in_tdata[8:0];
      s1_char_r   <= in_tdata[24:9];
      s1_button_r <= in_tdata[28:25];
      s1_now_r    <= in_tdata[60:29];
      s1_query_r  <= in_tdata[69:61];
    end
  end

  assign key_diff   = s1_now_r - key_time_r;
  assign key_due    = key_diff > {16'd0, (map_a_state == MAP_HELD) ? key_delay_r : key_rate_r};
  assign mouse_diff = s1_now_r - mouse_time_r;
  assign mouse_due  = mouse_diff >
                      {16'd0, (mouse_phase_r == MAP_HELD) ? mouse_delay_r : mouse_rate_r};
  assign button_ok  = (s1_button_r != '0) && (32'(s1_button_r) <= MOUSE_BUTTONS);

  always_comb begin
    repeat_key_nxt    = repeat_key_r;
    repeat_char_nxt   = repeat_char_r;
    stack_count_nxt   = stack_count_r;
    key_time_nxt      = key_time_r;
    frame_key_nxt     = frame_key_r;
    frame_char_nxt    = frame_char_r;
    pressed_key_nxt   = pressed_key_r;
    released_key_nxt  = released_key_r;
    held_buttons_nxt  = held_buttons_r;
    repeat_button_nxt = repeat_button_r;
    mouse_phase_nxt   = mouse_phase_r;
    drag_nxt          = drag_r;
    mouse_time_nxt    = mouse_time_r;
    frame_button_nxt  = frame_button_r;
    map_wr            = '{en: 1'b0, addr: key_index(s1_key_r), data: MAP_UP};
    push              = 1'b0;
    flag              = 1'b0;
    poll              = 1'b0;

    unique case (s1_func_r)
      FN_KEY_DOWN: begin
        push = (repeat_key_r != '0) && !is_modifier(repeat_key_r) &&
               (32'(stack_count_r) < STACK_DEPTH);
        if (push) stack_count_nxt = stack_count_r + 1'b1;
        map_wr           = '{en: key_in_range(s1_key_r), addr: key_index(s1_key_r),
                             data: MAP_HELD};
        pressed_key_nxt  = s1_key_r;
        frame_key_nxt    = s1_key_r;
        frame_char_nxt   = s1_char_r;
        repeat_key_nxt   = s1_key_r;
        repeat_char_nxt  = s1_char_r;
        key_time_nxt     = s1_now_r;
        released_key_nxt = '0;
        flag             = 1'b1;
      end
      FN_KEY_UP: begin
        map_wr = '{en: key_in_range(s1_key_r), addr: key_index(s1_key_r), data: MAP_UP};
        if (repeat_key_r == s1_key_r) begin
          repeat_key_nxt  = '0;
          repeat_char_nxt = '0;
        end
        released_key_nxt = s1_key_r;
        flag             = 1'b1;
      end
      FN_MOUSE_DOWN: begin
        if (button_ok) begin
          frame_button_nxt  = s1_button_r;
          repeat_button_nxt = s1_button_r;
          held_buttons_nxt  = held_buttons_r | (HELD_W'(1) << (s1_button_r - 1'b1));
          mouse_phase_nxt   = MAP_HELD;
          drag_nxt          = DRAG_PRESSED;
          mouse_time_nxt    = s1_now_r;
          flag              = 1'b1;
        end
      end
      FN_MOUSE_UP: begin
        if (button_ok) begin
          held_buttons_nxt  = held_buttons_r & ~(HELD_W'(1) << (s1_button_r - 1'b1));
          repeat_button_nxt = '0;
          drag_nxt          = DRAG_IDLE;
          mouse_phase_nxt   = MAP_UP;
          flag              = 1'b1;
        end
      end
      FN_POLL: begin
        poll = 1'b1;
        if (map_a_state != MAP_UP) begin
          if (key_due) begin
            key_time_nxt = s1_now_r;
            if (map_a_state == MAP_HELD) begin
              map_wr = '{en: key_in_range(repeat_key_r), addr: key_index(repeat_key_r),
                         data: MAP_REPEAT};
            end
            frame_key_nxt  = repeat_key_r;
            frame_char_nxt = repeat_char_r;
            flag           = 1'b1;
          end
        end else if (stack_count_r != '0) begin
          // Released repeat key: resume the one pressed before it.
          stack_count_nxt = stack_count_r - 1'b1;
          repeat_key_nxt  = stk_rd_r.key;
          repeat_char_nxt = stk_rd_r.chr;
          key_time_nxt    = s1_now_r;
        end
        if (mouse_phase_r != MAP_UP) begin
          drag_nxt = (drag_r == DRAG_PRESSED) ? DRAG_IDLE : DRAG_ACTIVE;
          if (mouse_due) begin
            mouse_time_nxt = s1_now_r;
            if (mouse_phase_r == MAP_HELD) mouse_phase_nxt = MAP_REPEAT;
            frame_button_nxt = repeat_button_r;
            flag             = 1'b1;
          end
        end
      end
      default: ;
    endcase

    // Write back only when the item completes.
    map_wr.en = map_wr.en && fire;

    // Forward this item's own map write to the query read.
    if (map_wr.en && key_in_range(s1_query_r) && (map_wr.addr == key_index(s1_query_r)))
      query_state = map_wr.data;
    else
      query_state = map_b_state;

    out_data_nxt = {4'd0, query_state, flag, drag_nxt, held_buttons_nxt,
                    frame_button_nxt, released_key_nxt, pressed_key_nxt,
                    frame_char_nxt, frame_key_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      repeat_key_r    <= '0;
      repeat_char_r   <= '0;
      stack_count_r   <= '0;
      key_time_r      <= '0;
      frame_key_r     <= '0;
      frame_char_r    <= '0;
      pressed_key_r   <= '0;
      released_key_r  <= '0;
      held_buttons_r  <= '0;
      repeat_button_r <= '0;
      mouse_phase_r   <= MAP_UP;
      drag_r          <= DRAG_IDLE;
      mouse_time_r    <= '0;
      frame_button_r  <= '0;
    end else begin
      if (in_accept) s1_valid_r <= 1'b1;
      else if (fire) s1_valid_r <= 1'b0;

      if (fire) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;

      if (fire) begin
        repeat_key_r    <= repeat_key_nxt;
        repeat_char_r   <= repeat_char_nxt;
        stack_count_r   <= stack_count_nxt;
        key_time_r      <= key_time_nxt;
        pressed_key_r   <= pressed_key_nxt;
        released_key_r  <= released_key_nxt;
        held_buttons_r  <= held_buttons_nxt;
        repeat_button_r <= repeat_button_nxt;
        mouse_phase_r   <= mouse_phase_nxt;
        drag_r          <= drag_nxt;
        mouse_time_r    <= mouse_time_nxt;
        // A poll reports the frame values, then drops them.
        frame_key_r     <= poll ? '0 : frame_key_nxt;
        frame_char_r    <= poll ? '0 : frame_char_nxt;
        frame_button_r  <= poll ? '0 : frame_button_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) out_data_r <= out_data_nxt;
  end

endmodule

### src/kmar_checker.sv
`include "key_and_mouse_autorepeat_defines.svh"

module kmar_checker
  import kmar_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_W-1:0]  out_tdata
);

  `KMAR_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result beat changed")
  `KMAR_ASSERT_NEXT(a_accept_gap, in_tvalid && in_tready, !in_tready, "input accepted in two adjacent cycles")
  `KMAR_ASSERT_RST(a_reset_quiet, !rst_n, !out_tvalid && !in_tready, "channels active right after reset")
  `KMAR_ASSERT_NOW(a_drag_code, out_tvalid, out_tdata[56:55] != 2'd3, "drag_state holds an unused code")
  `KMAR_ASSERT_NOW(a_query_code, out_tvalid, out_tdata[59:58] != 2'd3, "query_state holds an unused code")

endmodule

bind key_and_mouse_autorepeat kmar_checker u_kmar_checker (.*);
